@@ rtl/core/ffba_pkg.sv @@
package ffba_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'd1;

  localparam logic [DATA_W-1:0] HEAP_BASE_RST  = 32'd65536;
  localparam logic [DATA_W-1:0] HEAP_LIMIT_RST = 32'd16842752;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] address;
  } in_data_t;

  typedef struct packed {
    logic [DATA_W-1:0] address_res;
    logic [DATA_W-1:0] copy_bytes;
    logic [1:0]        status;
  } out_data_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_FIND_EVAL,
    S_FIT,
    S_APPEND,
    S_FREE_OLD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic mode_fit;
    logic set_zero;
    logic set_nospace;
    logic set_badfree;
    logic take;
    logic append;
    logic mark_old_free;
    logic set_copy;
    logic res_addr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       size_zero;
    logic       addr_zero;
    logic       hit;
    logic       miss;
    logic       old_free;
    logic       old_fits;
    logic       full;
    logic       fits;
    logic       is_move;
  } sts_t;

endpackage

@@ rtl/core/first_fit_block_allocator_top.sv @@
// A zero size, a null free or the unused code goes straight from decode to the result beat;
// allocate and free walk the block table, and a reallocate that has to move walks it twice;
// a stalled result holds the block until the earlier result is taken.
// Throughput: one item at a time; the next input beat can be taken in the same cycle as the result is
// offered, and the table walk reads one entry per cycle, so blocks in use set the rate.
// Reset is synchronous and active low; it empties the table, restores both heap
// registers and places the break at the heap base; no clearing pass is needed.
module first_fit_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ffba_pkg::in_data_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ffba_pkg::out_data_t            out_data,
  input  logic                           cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffba_pkg::DATA_W-1:0]    cfg_wdata
);
  import ffba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffba_dpath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ rtl/core/ffba_ctrl.sv @@
module ffba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ffba_pkg::cmd_t cmd,
  input  ffba_pkg::sts_t sts
);
  import ffba_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.func)
          FUNC_ALLOC: begin
            if (sts.size_zero) begin
              cmd.set_zero = 1'b1;
              state_nxt    = S_RESP;
            end else begin
              state_nxt = S_FIT;
            end
          end
          FUNC_FREE: begin
            state_nxt = sts.addr_zero ? S_RESP : S_FIND;
          end
          FUNC_REALLOC: begin
            if (!sts.addr_zero) begin
              state_nxt = S_FIND;
            end else if (sts.size_zero) begin
              cmd.set_zero = 1'b1;
              state_nxt    = S_RESP;
            end else begin
              state_nxt = S_FIT;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_FIND: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = S_FIND_EVAL;
        end else if (sts.miss) begin
          cmd.set_badfree = 1'b1;
          state_nxt       = S_RESP;
        end
      end
      S_FIND_EVAL: begin
        if (sts.old_free) begin
          cmd.set_badfree = 1'b1;
          state_nxt       = S_RESP;
        end else if (sts.func == FUNC_FREE) begin
          cmd.mark_old_free = 1'b1;
          state_nxt         = S_RESP;
        end else if (sts.old_fits) begin
          cmd.res_addr = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          state_nxt = S_FIT;
        end
      end
      S_FIT: begin
        cmd.scan     = 1'b1;
        cmd.mode_fit = 1'b1;
        if (sts.hit) begin
          cmd.take  = 1'b1;
          state_nxt = sts.is_move ? S_FREE_OLD : S_RESP;
        end else if (sts.miss) begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        if (sts.full || !sts.fits) begin
          cmd.set_nospace = 1'b1;
          state_nxt       = S_RESP;
        end else begin
          cmd.append = 1'b1;
          state_nxt  = sts.is_move ? S_FREE_OLD : S_RESP;
        end
      end
      S_FREE_OLD: begin
        cmd.mark_old_free = 1'b1;
        cmd.set_copy      = 1'b1;
        state_nxt         = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/ffba_dpath.sv @@
module ffba_dpath #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ffba_pkg::in_data_t               in_data,
  output ffba_pkg::out_data_t              out_data,
  input  logic                             cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffba_pkg::DATA_W-1:0]      cfg_wdata,
  input  ffba_pkg::cmd_t                   cmd,
  output ffba_pkg::sts_t                   sts
);
  import ffba_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [DATA_W-1:0] HDR     = DATA_W'(HEADER_BYTES);

  logic [DATA_W-1:0] start_mem [MAX_BLOCKS];
  logic [DATA_W-1:0] len_mem   [MAX_BLOCKS];
  logic              free_mem  [MAX_BLOCKS];

  logic [DATA_W-1:0] start_q_r, len_q_r;
  logic              free_q_r;

  logic [1:0]        func_r;
  logic [DATA_W-1:0] size_r, addr_r;
  logic [DATA_W-1:0] base_r, limit_r, break_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              chk_valid_r, chk_valid_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]  old_idx_r;
  logic [DATA_W-1:0] old_len_r;
  logic              old_free_r;
  logic [DATA_W-1:0] res_r, copy_r;
  logic [1:0]        st_r;
  out_data_t         out_r;

  logic              hit;
  logic              fit_match, find_match;
  logic [DATA_W+1:0] end_sum;
  logic              wr_en, wr_free;
  logic [IDX_W-1:0]  wr_idx;

  assign find_match = ((start_q_r + HDR) == addr_r);
  assign fit_match  = free_q_r && (len_q_r >= size_r);
  assign hit        = chk_valid_r && (cmd.mode_fit ? fit_match : find_match);
  assign end_sum    = {2'b00, break_r} + {2'b00, HDR} + {2'b00, size_r};

  always_comb begin
    rd_idx_nxt    = '0;
    chk_valid_nxt = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    if (cmd.scan && (rd_idx_r < count_r)) begin
      rd_idx_nxt    = rd_idx_r + CNT_W'(1);
      chk_valid_nxt = 1'b1;
      chk_idx_nxt   = rd_idx_r[IDX_W-1:0];
    end else if (cmd.scan) begin
      rd_idx_nxt = rd_idx_r;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_free = 1'b0;
    wr_idx  = chk_idx_r;
    if (cmd.take) begin
      wr_en = 1'b1;
    end else if (cmd.mark_old_free) begin
      wr_en   = 1'b1;
      wr_free = 1'b1;
      wr_idx  = old_idx_r;
    end else if (cmd.append) begin
      wr_en  = 1'b1;
      wr_idx = count_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      free_mem[wr_idx] <= wr_free;
    end
    if (cmd.append) begin
      start_mem[count_r[IDX_W-1:0]] <= break_r;
      len_mem[count_r[IDX_W-1:0]]   <= size_r;
    end
    start_q_r <= start_mem[rd_idx_r[IDX_W-1:0]];
    len_q_r   <= len_mem[rd_idx_r[IDX_W-1:0]];
    free_q_r  <= free_mem[rd_idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= HEAP_BASE_RST;
      limit_r     <= HEAP_LIMIT_RST;
      break_r     <= HEAP_BASE_RST;
      count_r     <= '0;
      rd_idx_r    <= '0;
      chk_valid_r <= 1'b0;
    end else begin
      rd_idx_r    <= rd_idx_nxt;
      chk_valid_r <= chk_valid_nxt;
      if (cfg_we && (cfg_index == REG_HEAP_BASE)) begin
        base_r <= cfg_wdata;
        if (count_r == '0) begin
          break_r <= cfg_wdata;
        end
      end
      if (cfg_we && (cfg_index == REG_HEAP_LIMIT)) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.append) begin
        count_r <= count_r + CNT_W'(1);
        break_r <= end_sum[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    if (cmd.load) begin
      func_r <= in_data.func;
      size_r <= in_data.size;
      addr_r <= in_data.address;
      res_r  <= '0;
      copy_r <= '0;
      st_r   <= ST_OK;
    end
    if (cmd.scan && !cmd.mode_fit && hit) begin
      old_idx_r  <= chk_idx_r;
      old_len_r  <= len_q_r;
      old_free_r <= free_q_r;
    end
    if (cmd.set_zero) begin
      st_r <= ST_ZERO;
    end
    if (cmd.set_nospace) begin
      st_r <= ST_NOSPACE;
    end
    if (cmd.set_badfree) begin
      st_r <= ST_BADFREE;
    end
    if (cmd.take) begin
      res_r <= start_q_r + HDR;
    end
    if (cmd.append) begin
      res_r <= break_r + HDR;
    end
    if (cmd.res_addr) begin
      res_r <= addr_r;
    end
    if (cmd.set_copy) begin
      copy_r <= old_len_r;
    end
    if (cmd.emit) begin
      out_r.address_res <= res_r;
      out_r.copy_bytes  <= copy_r;
      out_r.status      <= st_r;
    end
  end

  assign sts.func      = func_r;
  assign sts.size_zero = (size_r == '0);
  assign sts.addr_zero = (addr_r == '0);
  assign sts.hit       = hit;
  assign sts.miss      = !chk_valid_r && (rd_idx_r >= count_r);
  assign sts.old_free  = old_free_r;
  assign sts.old_fits  = (old_len_r >= size_r);
  assign sts.full      = (count_r >= CNT_MAX);
  assign sts.fits      = (end_sum <= {2'b00, limit_r});
  assign sts.is_move   = (func_r == FUNC_REALLOC) && (addr_r != '0);

  assign out_data = out_r;

endmodule
